// File: rtl/core/mmpid_pkg.sv
`default_nettype none

package mmpid_pkg;

  // Field widths
  localparam int SMP_W   = 16;  // measured, target, gyro_rate
  localparam int GAIN_W  = 16;
  localparam int MODE_W  = 2;
  localparam int ERR_W   = 17;  // target - measured
  localparam int SUM_W   = 32;  // saturating error sum
  localparam int DRV_W   = 14;  // drive output

  // Configuration port
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 8'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_POS  = 2'd0,  // positional, gated integral
    MODE_DIR  = 2'd1,  // direction, clamped integral, gyro damping
    MODE_INC  = 2'd2,  // incremental with deadband
    MODE_HOLD = 2'd3   // no state change, output held
  } mode_t;

  // Control limits
  localparam int DRIVE_LIMIT = 6000;
  localparam int ILIM_DIR    = 2000;
  localparam int DEADBAND    = 400;
  localparam int INC_SAT     = 12001;  // any increment beyond this saturates the drive

  // Datapath widths
  localparam int XP_W   = 18;  // operand of proportional multiplier
  localparam int XD_W   = 19;  // operand of derivative multiplier
  localparam int PP_W   = 35;
  localparam int DP_W   = 36;
  localparam int IP_W   = 49;
  localparam int LIN_W  = 34;  // ki * e in incremental mode
  localparam int PI_W   = 12;  // integral term, within +/-2000
  localparam int NUM_W  = 42;  // common-denominator numerator
  localparam int INCQ_W = 16;

  // Constant divider: exact reciprocal multiply for magnitudes below 2^MAG_W
  localparam int MAG_W  = 25;
  localparam int RCP_W  = 26;
  localparam int LIM_W  = 26;
  localparam int PROD_W = 55;
  localparam int QMAG_W = 15;

  typedef enum logic [1:0] {
    DIV_100   = 2'd0,
    DIV_1000  = 2'd1,
    DIV_10000 = 2'd2
  } div_t;

  localparam logic [RCP_W-1:0] RCP_100   = 26'd42949673;  // ceil(2^32 / 100)
  localparam logic [RCP_W-1:0] RCP_1000  = 26'd34359739;  // ceil(2^35 / 1000)
  localparam logic [RCP_W-1:0] RCP_10000 = 26'd54975582;  // ceil(2^39 / 10000)
  localparam int SH_100   = 32;
  localparam int SH_1000  = 35;
  localparam int SH_10000 = 39;

  // Magnitude limits at or above which a quotient saturates
  localparam logic [LIM_W-1:0] PI_LIM_POS  = 26'd501000;
  localparam logic [LIM_W-1:0] PI_LIM_DIR  = 26'd20000000;
  localparam logic [LIM_W-1:0] NUM_LIM_POS = 26'd600100;
  localparam logic [LIM_W-1:0] NUM_LIM_DIR = 26'd6001000;
  localparam logic [LIM_W-1:0] NUM_LIM_INC = 26'd12001000;

  typedef struct packed {
    logic signed [ERR_W-1:0] e;     // effective error this item
    logic signed [ERR_W-1:0] e1;    // previous error
    logic signed [ERR_W-1:0] e2;    // error before that
    logic signed [SUM_W-1:0] sum;   // updated error sum
    logic signed [SMP_W-1:0] gyro;
  } front_t;

  typedef struct packed {
    logic              over;  // magnitude at or above the limit
    logic              neg;
    logic [QMAG_W-1:0] mag;   // truncated quotient magnitude, valid when not over
  } quot_t;

endpackage

`default_nettype wire

// File: rtl/core/mmpid_front.sv
`default_nettype none

module mmpid_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                accept,
  input  mmpid_pkg::mode_t                    mode,
  input  logic signed [mmpid_pkg::SMP_W-1:0]  measured,
  input  logic signed [mmpid_pkg::SMP_W-1:0]  target,
  input  logic signed [mmpid_pkg::SMP_W-1:0]  gyro_rate,
  output mmpid_pkg::front_t                   s1
);
  import mmpid_pkg::*;

  logic signed [ERR_W-1:0] error_now;
  logic signed [ERR_W-1:0] error_prev;
  logic signed [SUM_W-1:0] error_sum;

  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] err_db;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_next;

  // Error, deadband and saturating sum
  always_comb begin
    err = ERR_W'(target) - ERR_W'(measured);
    if ((err < ERR_W'(DEADBAND)) && (err > -ERR_W'(DEADBAND))) begin
      err_db = '0;
    end else begin
      err_db = err;
    end
    sum_wide = (SUM_W+1)'(error_sum) + (SUM_W+1)'(err);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
  end

  // Error history, updated once per accepted item outside hold mode
  always_ff @(posedge clk) begin
    if (rst) begin
      error_now  <= '0;
      error_prev <= '0;
      error_sum  <= '0;
    end else if (accept) begin
      case (mode)
        MODE_POS, MODE_DIR: begin
          error_prev <= error_now;
          error_now  <= err;
          error_sum  <= sum_next;
        end
        MODE_INC: begin
          error_prev <= error_now;
          error_now  <= err_db;
        end
        default: begin
        end
      endcase
    end
  end

  // First pipeline register
  always_ff @(posedge clk) begin
    if (en) begin
      s1.e    <= (mode == MODE_INC) ? err_db : err;
      s1.e1   <= error_now;
      s1.e2   <= error_prev;
      s1.sum  <= sum_next;
      s1.gyro <= gyro_rate;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mmpid_qdiv.sv
`default_nettype none

module mmpid_qdiv #(
  parameter int VAL_W = mmpid_pkg::NUM_W
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [VAL_W-1:0]           value,
  input  mmpid_pkg::div_t                   code,
  input  logic [mmpid_pkg::LIM_W-1:0]       lim,
  output mmpid_pkg::quot_t                  quot
);
  import mmpid_pkg::*;

  logic             neg;
  logic [VAL_W-1:0] abs_val;
  logic             over;
  logic [RCP_W-1:0] recip;

  logic             a_neg;
  logic             a_over;
  logic [MAG_W-1:0] a_mag;
  logic [RCP_W-1:0] a_recip;
  div_t             a_code;

  logic [PROD_W-1:0] prod;
  logic [QMAG_W-1:0] q;

  // Stage a: sign, magnitude, range check, reciprocal select
  always_comb begin
    neg     = value[VAL_W-1];
    abs_val = neg ? $unsigned(-value) : $unsigned(value);
    over    = abs_val >= VAL_W'(lim);
    case (code)
      DIV_100:   recip = RCP_100;
      DIV_1000:  recip = RCP_1000;
      DIV_10000: recip = RCP_10000;
      default:   recip = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_neg   <= neg;
      a_over  <= over;
      a_mag   <= abs_val[MAG_W-1:0];
      a_recip <= recip;
      a_code  <= code;
    end
  end

  // Stage b: reciprocal multiply, quotient taken from the shifted product
  always_comb begin
    prod = PROD_W'(a_mag) * PROD_W'(a_recip);
    case (a_code)
      DIV_100:   q = prod[SH_100 +: QMAG_W];
      DIV_1000:  q = prod[SH_1000 +: QMAG_W];
      DIV_10000: q = prod[SH_10000 +: QMAG_W];
      default:   q = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot.over <= a_over;
      quot.neg  <= a_neg;
      quot.mag  <= q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/multi_mode_pid_controller.sv
`default_nettype none

// PID controller with positional, direction (gyro damped) and incremental
// modes. Takes one item per clock when not stalled and returns one drive item
// per input item. Pipeline: input register, three parallel gain multipliers,
// a two-stage reciprocal divider for the integral term, the numerator adder,
// a second two-stage divider and the drive register that also holds the
// incremental accumulator. An output stall with a valid result freezes the
// whole pipeline and raises in_stall. Registers (mode, gain_p, gain_i, gain_d)
// are written through the configuration port, which is always ready; the user
// must write them only while no item is in flight; the block does not enforce
// it. Mode 3 leaves all state untouched and returns the held drive value.
module multi_mode_pid_controller (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [mmpid_pkg::SMP_W-1:0]      measured,
  input  logic signed [mmpid_pkg::SMP_W-1:0]      target,
  input  logic signed [mmpid_pkg::SMP_W-1:0]      gyro_rate,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [mmpid_pkg::DRV_W-1:0]      drive,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mmpid_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mmpid_pkg::CFG_DAT_W-1:0]         cfg_data
);
  import mmpid_pkg::*;

  localparam int PIPE_N = 7;

  mode_t              mode;
  logic [GAIN_W-1:0]  gain_p;
  logic [GAIN_W-1:0]  gain_i;
  logic [GAIN_W-1:0]  gain_d;

  logic               en;
  logic               accept;
  logic [PIPE_N-1:0]  vld;

  front_t             s1;

  logic signed [XP_W-1:0]  xp;
  logic signed [XD_W-1:0]  xd;
  logic signed [SUM_W-1:0] xi;
  logic signed [XP_W-1:0]  d1;
  logic signed [XD_W-1:0]  d2;

  logic signed [PP_W-1:0]  s2_pp;
  logic signed [DP_W-1:0]  s2_dp;
  logic signed [IP_W-1:0]  s2_ip;
  logic signed [PP_W-1:0]  s3_pp;
  logic signed [DP_W-1:0]  s3_dp;
  logic signed [LIN_W-1:0] s3_lin;
  logic signed [PP_W-1:0]  s4_pp;
  logic signed [DP_W-1:0]  s4_dp;
  logic signed [LIN_W-1:0] s4_lin;

  div_t              pi_code;
  logic [LIM_W-1:0]  pi_lim;
  quot_t             pi_q;

  logic signed [PI_W-1:0]  pi_abs;
  logic signed [PI_W-1:0]  pi_val;
  logic signed [NUM_W-1:0] pp_x;
  logic signed [NUM_W-1:0] dp_x;
  logic signed [NUM_W-1:0] lin_x;
  logic signed [NUM_W-1:0] pi_x;
  logic signed [NUM_W-1:0] num_next;
  logic signed [NUM_W-1:0] s5_num;

  div_t              num_code;
  logic [LIM_W-1:0]  num_lim;
  quot_t             num_q;

  logic signed [INCQ_W-1:0] q_abs;
  logic signed [INCQ_W-1:0] q_val;
  logic signed [INCQ_W-1:0] inc;
  logic signed [INCQ_W:0]   acc;
  logic signed [DRV_W-1:0]  drive_value;
  logic signed [DRV_W-1:0]  drive_next;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_POS;
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:   mode   <= mode_t'(cfg_data[MODE_W-1:0]);
        CFG_GAIN_P: gain_p <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I: gain_i <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D: gain_d <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline advance: everything moves unless the result is held
  assign en       = !out_valid || !out_stall;
  assign accept   = in_valid && en;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[PIPE_N-2:0], in_valid};
      out_valid <= vld[PIPE_N-1];
    end
  end

  // Stage 1: error history and input register
  mmpid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .accept    (accept),
    .mode      (mode),
    .measured  (measured),
    .target    (target),
    .gyro_rate (gyro_rate),
    .s1        (s1)
  );

  // Stage 2: gain multipliers, operands chosen by mode
  always_comb begin
    d1 = XP_W'(s1.e) - XP_W'(s1.e1);
    d2 = XD_W'(s1.e) - (XD_W'(s1.e1) <<< 1) + XD_W'(s1.e2);
    case (mode)
      MODE_POS: begin
        xp = XP_W'(s1.e);
        xd = XD_W'(d1);
        xi = s1.sum;
      end
      MODE_DIR: begin
        xp = XP_W'(s1.e);
        xd = XD_W'(s1.gyro);
        xi = s1.sum;
      end
      MODE_INC: begin
        xp = d1;
        xd = d2;
        xi = SUM_W'(s1.e);
      end
      default: begin
        xp = '0;
        xd = '0;
        xi = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pp <= PP_W'($signed({1'b0, gain_p})) * PP_W'(xp);
      s2_dp <= DP_W'($signed({1'b0, gain_d})) * DP_W'(xd);
      s2_ip <= IP_W'($signed({1'b0, gain_i})) * IP_W'(xi);
    end
  end

  // Stages 3 and 4: integral term divider
  always_comb begin
    case (mode)
      MODE_POS: begin
        pi_code = DIV_1000;
        pi_lim  = PI_LIM_POS;
      end
      default: begin
        pi_code = DIV_10000;
        pi_lim  = PI_LIM_DIR;
      end
    endcase
  end

  mmpid_qdiv #(
    .VAL_W (IP_W)
  ) u_pi_div (
    .clk   (clk),
    .en    (en),
    .value (s2_ip),
    .code  (pi_code),
    .lim   (pi_lim),
    .quot  (pi_q)
  );

  // Proportional, derivative and incremental ki * e products ride alongside the divider
  always_ff @(posedge clk) begin
    if (en) begin
      s3_pp  <= s2_pp;
      s3_dp  <= s2_dp;
      s3_lin <= $signed(s2_ip[LIN_W-1:0]);
      s4_pp  <= s3_pp;
      s4_dp  <= s3_dp;
      s4_lin <= s3_lin;
    end
  end

  // Stage 5: integral gate or clamp, numerator over common denominator
  always_comb begin
    pi_abs = $signed({1'b0, pi_q.mag[PI_W-2:0]});
    case (mode)
      MODE_POS: begin
        if (pi_q.over) begin
          pi_val = '0;
        end else begin
          pi_val = pi_q.neg ? -pi_abs : pi_abs;
        end
      end
      MODE_DIR: begin
        if (pi_q.over) begin
          pi_val = pi_q.neg ? -PI_W'(ILIM_DIR) : PI_W'(ILIM_DIR);
        end else begin
          pi_val = pi_q.neg ? -pi_abs : pi_abs;
        end
      end
      default: pi_val = '0;
    endcase

    pp_x  = NUM_W'(s4_pp);
    dp_x  = NUM_W'(s4_dp);
    lin_x = NUM_W'(s4_lin);
    pi_x  = NUM_W'(pi_val);
    case (mode)
      MODE_POS: num_next = pp_x - dp_x + pi_x * NUM_W'(100);
      MODE_DIR: num_next = pp_x * NUM_W'(10) - dp_x + pi_x * NUM_W'(1000);
      MODE_INC: num_next = pp_x * NUM_W'(10) + lin_x + dp_x * NUM_W'(10);
      default:  num_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_num <= num_next;
    end
  end

  // Stages 6 and 7: numerator divider
  always_comb begin
    case (mode)
      MODE_POS: begin
        num_code = DIV_100;
        num_lim  = NUM_LIM_POS;
      end
      MODE_DIR: begin
        num_code = DIV_1000;
        num_lim  = NUM_LIM_DIR;
      end
      default: begin
        num_code = DIV_1000;
        num_lim  = NUM_LIM_INC;
      end
    endcase
  end

  mmpid_qdiv #(
    .VAL_W (NUM_W)
  ) u_num_div (
    .clk   (clk),
    .en    (en),
    .value (s5_num),
    .code  (num_code),
    .lim   (num_lim),
    .quot  (num_q)
  );

  // Stage 8: output clamp, incremental accumulation
  always_comb begin
    q_abs = $signed({1'b0, num_q.mag});
    q_val = num_q.neg ? -q_abs : q_abs;
    if (num_q.over) begin
      inc = num_q.neg ? -INCQ_W'(INC_SAT) : INCQ_W'(INC_SAT);
    end else begin
      inc = q_val;
    end
    acc = (INCQ_W+1)'(drive_value) + (INCQ_W+1)'(inc);
    case (mode)
      MODE_POS, MODE_DIR: begin
        if (num_q.over) begin
          drive_next = num_q.neg ? -DRV_W'(DRIVE_LIMIT) : DRV_W'(DRIVE_LIMIT);
        end else begin
          drive_next = q_val[DRV_W-1:0];
        end
      end
      MODE_INC: begin
        if (acc > (INCQ_W+1)'(DRIVE_LIMIT)) begin
          drive_next = DRV_W'(DRIVE_LIMIT);
        end else if (acc < -(INCQ_W+1)'(DRIVE_LIMIT)) begin
          drive_next = -DRV_W'(DRIVE_LIMIT);
        end else begin
          drive_next = acc[DRV_W-1:0];
        end
      end
      default: drive_next = drive_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_value <= '0;
    end else if (en && vld[PIPE_N-1]) begin
      drive_value <= drive_next;
    end
  end

  assign drive = drive_value;

endmodule

`default_nettype wire
